// ===== rtl/ttcsp_pkg.sv =====
`timescale 1ns / 1ps
package ttcsp_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [CFG_IW-1:0] {
    REG_COS_Z        = 3'd0,
    REG_SIN_Z        = 3'd1,
    REG_COS_X        = 3'd2,
    REG_SIN_X        = 3'd3,
    REG_DEPTH_OFFSET = 3'd4,
    REG_X_PROJ_SCALE = 3'd5,
    REG_Y_PROJ_SCALE = 3'd6
  } reg_idx_t;

  localparam int SCREEN_WIDTH_DEF  = 512;
  localparam int SCREEN_HEIGHT_DEF = 480;

  localparam int PROJ_Q = 65543;
  localparam int PROJ_B = -6554;

  localparam logic signed [17:0] COS_Z_RST        = 18'sd65536;
  localparam logic signed [17:0] SIN_Z_RST        = 18'sd0;
  localparam logic signed [17:0] COS_X_RST        = 18'sd65536;
  localparam logic signed [17:0] SIN_X_RST        = 18'sd0;
  localparam logic signed [31:0] DEPTH_OFFSET_RST = 32'sd524288;
  localparam logic [23:0]        X_PROJ_SCALE_RST = 24'd69905;
  localparam logic [23:0]        Y_PROJ_SCALE_RST = 24'd65536;

  localparam int ROT_LAT  = 5;
  localparam int DIV_NW   = 56;
  localparam int DIV_DW   = 32;
  localparam int LANE_LAT = ROT_LAT + 2 + DIV_NW + 3;
  localparam int FACE_LAT = 12;
  localparam int ZP_W     = 50;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
  } tri_t;

  typedef struct packed {
    logic signed [15:0] screen_x0;
    logic signed [15:0] screen_y0;
    logic signed [15:0] screen_x1;
    logic signed [15:0] screen_y1;
    logic signed [15:0] screen_x2;
    logic signed [15:0] screen_y2;
    logic signed [31:0] depth_sum;
    logic [3:0]         shade_level;
  } res_t;

  typedef struct packed {
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [17:0] cos_z;
    logic signed [17:0] sin_z;
    logic signed [17:0] cos_x;
    logic signed [17:0] sin_x;
    logic signed [31:0] depth_offset;
    logic [23:0]        x_proj_scale;
    logic [23:0]        y_proj_scale;
  } xform_t;

  typedef struct packed {
    logic signed [15:0]     sx;
    logic signed [15:0]     sy;
    logic signed [ZP_W-1:0] zp;
  } lane_res_t;

  typedef struct packed {
    logic       keep;
    logic [3:0] level;
  } face_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ttcsp_if.sv =====
`timescale 1ns / 1ps
interface ttcsp_tri_if;
  import ttcsp_pkg::*;
  logic valid;
  logic ready;
  tri_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ttcsp_res_if;
  import ttcsp_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ttcsp_cfg_if;
  import ttcsp_pkg::*;
  logic valid;
  logic ready;
  cfg_wr_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/triangle_transform_cull_shade_project.sv =====
`timescale 1ns / 1ps
// Port      Role    Beat
// triangle  sink    one triangle, three Q16.16 vertices
// result    source  six screen coordinates, depth sum, shade level
// cfg       sink    register index and write data, always ready
//
// One triangle is taken per cycle unless a held result stalls the pipeline.
// Each vertex lane divides x, y and depth by w in three 56-stage pipelined dividers.
// Culled triangles leave no beat. Reset is synchronous and empties the pipeline.
// A held result stalls the whole pipeline and deasserts triangle.ready.
module triangle_transform_cull_shade_project #(
  parameter int SCREEN_WIDTH  = ttcsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttcsp_pkg::SCREEN_HEIGHT_DEF
) (
  input logic          clk,
  input logic          rst,
  ttcsp_tri_if.sink    triangle,
  ttcsp_res_if.source  result,
  ttcsp_cfg_if.sink    cfg
);
  import ttcsp_pkg::*;

  localparam int FDLY = LANE_LAT - ROT_LAT - FACE_LAT;

  xform_t              xf;
  logic                adv;
  logic [LANE_LAT-1:0] vld;
  vtx_t                vin  [3];
  vtx_t                vrot [3];
  lane_res_t           lres [3];
  face_res_t           fres;
  face_res_t           face_q [FDLY];

  assign cfg.ready      = 1'b1;
  assign adv            = !result.valid || result.ready;
  assign triangle.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      xf.cos_z        <= COS_Z_RST;
      xf.sin_z        <= SIN_Z_RST;
      xf.cos_x        <= COS_X_RST;
      xf.sin_x        <= SIN_X_RST;
      xf.depth_offset <= DEPTH_OFFSET_RST;
      xf.x_proj_scale <= X_PROJ_SCALE_RST;
      xf.y_proj_scale <= Y_PROJ_SCALE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_COS_Z:        xf.cos_z        <= cfg.data.value[17:0];
        REG_SIN_Z:        xf.sin_z        <= cfg.data.value[17:0];
        REG_COS_X:        xf.cos_x        <= cfg.data.value[17:0];
        REG_SIN_X:        xf.sin_x        <= cfg.data.value[17:0];
        REG_DEPTH_OFFSET: xf.depth_offset <= cfg.data.value;
        REG_X_PROJ_SCALE: xf.x_proj_scale <= cfg.data.value[23:0];
        REG_Y_PROJ_SCALE: xf.y_proj_scale <= cfg.data.value[23:0];
        default: ;
      endcase
    end
  end

  assign vin[0] = '{x: triangle.data.v0_x, y: triangle.data.v0_y, z: triangle.data.v0_z};
  assign vin[1] = '{x: triangle.data.v1_x, y: triangle.data.v1_y, z: triangle.data.v1_z};
  assign vin[2] = '{x: triangle.data.v2_x, y: triangle.data.v2_y, z: triangle.data.v2_z};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ttcsp_lane #(
      .SCREEN_WIDTH(SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_lane (
      .clk(clk), .en(adv), .vin(vin[i]), .xf(xf), .vrot(vrot[i]), .res(lres[i])
    );
  end

  ttcsp_face u_face (
    .clk(clk), .en(adv), .v0(vrot[0]), .v1(vrot[1]), .v2(vrot[2]), .res(fres)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      face_q[0] <= fres;
      for (int i = 1; i < FDLY; i++) begin
        face_q[i] <= face_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[LANE_LAT-2:0], triangle.valid};
      result.valid <= vld[LANE_LAT-1] && face_q[FDLY-1].keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.data.screen_x0   <= lres[0].sx;
      result.data.screen_y0   <= lres[0].sy;
      result.data.screen_x1   <= lres[1].sx;
      result.data.screen_y1   <= lres[1].sy;
      result.data.screen_x2   <= lres[2].sx;
      result.data.screen_y2   <= lres[2].sy;
      result.data.depth_sum   <= sat32(64'(lres[0].zp) + 64'(lres[1].zp) + 64'(lres[2].zp));
      result.data.shade_level <= face_q[FDLY-1].level;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !triangle.ready)
    else $error("input accepted while result stalled");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld[LANE_LAT-1]))
    else $error("result without a triangle in the last stage");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.shade_level <= 4'd12)
    else $error("shade level out of range");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0) && !result.valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== rtl/ttcsp_div.sv =====
`timescale 1ns / 1ps
module ttcsp_div #(
  parameter int NW = 56,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] acc_q [NW];
  logic [DW-1:0] den_q [NW];

  logic [DW-1:0] rem_in [NW];
  logic [NW-1:0] acc_in [NW];
  logic [DW-1:0] den_in [NW];
  logic [DW-1:0] rem_n  [NW];
  logic [NW-1:0] acc_n  [NW];

  always_comb begin
    rem_in[0] = '0;
    acc_in[0] = num;
    den_in[0] = den;
    for (int i = 1; i < NW; i++) begin
      rem_in[i] = rem_q[i-1];
      acc_in[i] = acc_q[i-1];
      den_in[i] = den_q[i-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int i = 0; i < NW; i++) begin
      trial = {rem_in[i], acc_in[i][NW-1]};
      diff  = trial - {1'b0, den_in[i]};
      if (trial >= {1'b0, den_in[i]}) begin
        rem_n[i] = diff[DW-1:0];
        acc_n[i] = {acc_in[i][NW-2:0], 1'b1};
      end else begin
        rem_n[i] = trial[DW-1:0];
        acc_n[i] = {acc_in[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        rem_q[i] <= rem_n[i];
        acc_q[i] <= acc_n[i];
        den_q[i] <= den_in[i];
      end
    end
  end

  assign quo = acc_q[NW-1];

endmodule

// ===== rtl/ttcsp_lane.sv =====
`timescale 1ns / 1ps
module ttcsp_lane #(
  parameter int SCREEN_WIDTH  = ttcsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttcsp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  ttcsp_pkg::vtx_t     vin,
  input  ttcsp_pkg::xform_t   xf,
  output ttcsp_pkg::vtx_t     vrot,
  output ttcsp_pkg::lane_res_t res
);
  import ttcsp_pkg::*;

  localparam int SMAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SB   = $clog2(SMAX + 1);
  localparam int TW   = 34 + SB;
  localparam logic signed [SB:0] SW_S = (SB+1)'(SCREEN_WIDTH);
  localparam logic signed [SB:0] SH_S = (SB+1)'(SCREEN_HEIGHT);
  localparam logic signed [17:0] PQ   = 18'(PROJ_Q);

  typedef struct packed {
    logic               xneg;
    logic               yneg;
    logic               zneg;
    logic               wz;
    logic signed [40:0] bx;
    logic signed [40:0] by;
    logic signed [34:0] bz;
  } side_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic signed [49:0] r1_xc, r1_ys, r1_xs, r1_yc;
  logic signed [31:0] r1_z;
  logic signed [31:0] r2_x, r2_y, r2_z;
  logic signed [49:0] r3_yc, r3_zs, r3_ys, r3_zc;
  logic signed [31:0] r3_x;
  logic signed [31:0] r4_x, r4_y, r4_z;
  logic signed [31:0] r5_x, r5_y, r5_z;
  logic signed [50:0] r2_dx, r2_dy, r4_dy, r4_dz;

  assign r2_dx = {r1_xc[49], r1_xc} - {r1_ys[49], r1_ys};
  assign r2_dy = {r1_xs[49], r1_xs} + {r1_yc[49], r1_yc};
  assign r4_dy = {r3_yc[49], r3_yc} - {r3_zs[49], r3_zs};
  assign r4_dz = {r3_ys[49], r3_ys} + {r3_zc[49], r3_zc};

  always_ff @(posedge clk) begin
    if (en) begin
      r1_xc <= 50'(vin.x) * 50'(xf.cos_z);
      r1_ys <= 50'(vin.y) * 50'(xf.sin_z);
      r1_xs <= 50'(vin.x) * 50'(xf.sin_z);
      r1_yc <= 50'(vin.y) * 50'(xf.cos_z);
      r1_z  <= vin.z;
      r2_x  <= sat32(64'(r2_dx >>> 16));
      r2_y  <= sat32(64'(r2_dy >>> 16));
      r2_z  <= r1_z;
      r3_yc <= 50'(r2_y) * 50'(xf.cos_x);
      r3_zs <= 50'(r2_z) * 50'(xf.sin_x);
      r3_ys <= 50'(r2_y) * 50'(xf.sin_x);
      r3_zc <= 50'(r2_z) * 50'(xf.cos_x);
      r3_x  <= r2_x;
      r4_x  <= r3_x;
      r4_y  <= sat32(64'(r4_dy >>> 16));
      r4_z  <= sat32(64'(r4_dz >>> 16));
      r5_x  <= r4_x;
      r5_y  <= r4_y;
      r5_z  <= sat32(64'(r4_z) + 64'(xf.depth_offset));
    end
  end

  assign vrot = '{x: r5_x, y: r5_y, z: r5_z};

  logic signed [56:0] p1_xn, p1_yn;
  logic signed [49:0] p1_zm;
  logic signed [31:0] p1_w;
  logic signed [34:0] zn;
  logic signed [50:0] zd;
  side_t              side_in, p2_side;
  logic [55:0]        p2_xm, p2_ym, p2_zm;
  logic [31:0]        p2_wm;
  side_t              side_q [DIV_NW];

  assign zn = 35'(p1_zm >>> 16) + 35'(PROJ_B);
  assign zd = {zn, 16'b0};

  always_comb begin
    side_in.xneg = p1_xn[56] ^ p1_w[31];
    side_in.yneg = p1_yn[56] ^ p1_w[31];
    side_in.zneg = zd[50] ^ p1_w[31];
    side_in.wz   = (p1_w == '0);
    side_in.bx   = 41'(p1_xn >>> 16);
    side_in.by   = 41'(p1_yn >>> 16);
    side_in.bz   = zn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xn   <= 57'(r5_x) * 57'($signed({1'b0, xf.x_proj_scale}));
      p1_yn   <= 57'(r5_y) * 57'($signed({1'b0, xf.y_proj_scale}));
      p1_zm   <= 50'(r5_z) * 50'(PQ);
      p1_w    <= r5_z;
      p2_xm   <= p1_xn[56] ? 56'(-p1_xn) : 56'(p1_xn);
      p2_ym   <= p1_yn[56] ? 56'(-p1_yn) : 56'(p1_yn);
      p2_zm   <= zd[50] ? 56'(-zd) : 56'(zd);
      p2_wm   <= p1_w[31] ? 32'(-p1_w) : 32'(p1_w);
      p2_side <= side_in;
      side_q[0] <= p2_side;
      for (int i = 1; i < DIV_NW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [55:0] qx, qy, qz;

  ttcsp_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_x (
    .clk(clk), .en(en), .num(p2_xm), .den(p2_wm), .quo(qx)
  );
  ttcsp_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_y (
    .clk(clk), .en(en), .num(p2_ym), .den(p2_wm), .quo(qy)
  );
  ttcsp_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_z (
    .clk(clk), .en(en), .num(p2_zm), .den(p2_wm), .quo(qz)
  );

  side_t              sd;
  logic signed [56:0] qxs, qys, qzs;
  logic signed [31:0] p3_xp, p3_yp;
  logic signed [ZP_W-1:0] p3_zp, p4_zp, p5_zp;
  logic signed [32:0] xo, yo;
  logic signed [TW-1:0] p4_tx, p4_ty, tqx, tqy;
  logic signed [15:0] p5_sx, p5_sy;

  assign sd  = side_q[DIV_NW-1];
  assign qxs = sd.xneg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign qys = sd.yneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign qzs = sd.zneg ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
  assign xo  = 33'(p3_xp) + 33'sd65536;
  assign yo  = 33'(p3_yp) + 33'sd65536;
  assign tqx = p4_tx[TW-1] ? (p4_tx + TW'(131071)) >>> 17 : p4_tx >>> 17;
  assign tqy = p4_ty[TW-1] ? (p4_ty + TW'(131071)) >>> 17 : p4_ty >>> 17;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_xp <= sd.wz ? sat32(64'(sd.bx)) : sat32(64'(qxs));
      p3_yp <= sd.wz ? sat32(64'(sd.by)) : sat32(64'(qys));
      p3_zp <= sd.wz ? ZP_W'(sd.bz) : ZP_W'(qzs);
      p4_tx <= TW'(xo) * TW'(SW_S);
      p4_ty <= TW'(yo) * TW'(SH_S);
      p4_zp <= p3_zp;
      p5_sx <= sat16(64'(tqx));
      p5_sy <= sat16(64'(tqy));
      p5_zp <= p4_zp;
    end
  end

  assign res = '{sx: p5_sx, sy: p5_sy, zp: p5_zp};

endmodule

// ===== rtl/ttcsp_face.sv =====
`timescale 1ns / 1ps
module ttcsp_face (
  input  logic                 clk,
  input  logic                 en,
  input  ttcsp_pkg::vtx_t      v0,
  input  ttcsp_pkg::vtx_t      v1,
  input  ttcsp_pkg::vtx_t      v2,
  output ttcsp_pkg::face_res_t res
);
  import ttcsp_pkg::*;

  logic signed [32:0] f1_e [6];
  vtx_t               v0_q [8];
  logic signed [29:0] f2_e [6];
  logic signed [59:0] f3_p [6];
  logic signed [60:0] f4_n [3];
  logic signed [60:0] f5_n [3];
  logic [59:0]        f5_m;
  logic               f5_zero;
  logic signed [60:0] f6_n [3];
  logic [7:0]         f6_any;
  logic [2:0]         f6_lead [8];
  logic               f6_zero;
  logic signed [60:0] f7_n [3];
  logic [5:0]         f7_s;
  logic               f7_zero;
  logic signed [25:0] f8_n [3];
  logic               f8_zero;
  logic signed [57:0] f9_d [3];
  logic [51:0]        f9_q [3];
  logic               f9_apos, f9_zero;
  logic signed [59:0] f10_dot;
  logic [53:0]        f10_s;
  logic [51:0]        f10_a2;
  logic               f10_apos, f10_zero;
  logic [61:0]        f11_kk [13];
  logic [61:0]        f11_r;
  logic               f11_apos, f11_keep;

  logic [1:0]  s1;
  logic [63:0] mpad;
  logic [7:0]  any_n;
  logic [2:0]  lead_n [8];
  logic [5:0]  s2;
  logic [3:0]  cnt;
  logic        ok;
  logic signed [32:0] t;
  logic [59:0] m_n;

  always_comb begin
    s1 = 2'd3;
    for (int s = 3; s >= 0; s--) begin
      ok = 1'b1;
      for (int k = 0; k < 6; k++) begin
        t = f1_e[k] >>> (29 + s);
        if (t != '0 && t != '1) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        s1 = 2'(s);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 60; i++) begin
      m_n[i] = (f4_n[0][i] ^ f4_n[0][i+1]) | (f4_n[1][i] ^ f4_n[1][i+1])
             | (f4_n[2][i] ^ f4_n[2][i+1]);
    end
  end

  assign mpad = {4'b0, f5_m};

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      any_n[g]  = |mpad[g*8 +: 8];
      lead_n[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mpad[g*8 + b]) begin
          lead_n[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    logic [5:0] p;
    p = '0;
    for (int g = 0; g < 8; g++) begin
      if (f6_any[g]) begin
        p = {3'(g), f6_lead[g]};
      end
    end
    s2 = (p > 6'd24) ? 6'(p - 6'd24) : 6'd0;
  end

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 13; k++) begin
      if (f11_kk[k] <= f11_r) begin
        cnt = cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_e[0] <= 33'(v1.x) - 33'(v0.x);
      f1_e[1] <= 33'(v1.y) - 33'(v0.y);
      f1_e[2] <= 33'(v1.z) - 33'(v0.z);
      f1_e[3] <= 33'(v2.x) - 33'(v0.x);
      f1_e[4] <= 33'(v2.y) - 33'(v0.y);
      f1_e[5] <= 33'(v2.z) - 33'(v0.z);
      v0_q[0] <= v0;
      for (int i = 1; i < 8; i++) begin
        v0_q[i] <= v0_q[i-1];
      end
      for (int k = 0; k < 6; k++) begin
        f2_e[k] <= 30'(f1_e[k] >>> s1);
      end
      f3_p[0] <= 60'(f2_e[1]) * 60'(f2_e[5]);
      f3_p[1] <= 60'(f2_e[2]) * 60'(f2_e[4]);
      f3_p[2] <= 60'(f2_e[2]) * 60'(f2_e[3]);
      f3_p[3] <= 60'(f2_e[0]) * 60'(f2_e[5]);
      f3_p[4] <= 60'(f2_e[0]) * 60'(f2_e[4]);
      f3_p[5] <= 60'(f2_e[1]) * 60'(f2_e[3]);
      f4_n[0] <= 61'(f3_p[0]) - 61'(f3_p[1]);
      f4_n[1] <= 61'(f3_p[2]) - 61'(f3_p[3]);
      f4_n[2] <= 61'(f3_p[4]) - 61'(f3_p[5]);
      f5_n    <= f4_n;
      f5_m    <= m_n;
      f5_zero <= (f4_n[0] == '0) && (f4_n[1] == '0) && (f4_n[2] == '0);
      f6_n    <= f5_n;
      f6_any  <= any_n;
      f6_lead <= lead_n;
      f6_zero <= f5_zero;
      f7_n    <= f6_n;
      f7_s    <= s2;
      f7_zero <= f6_zero;
      for (int c = 0; c < 3; c++) begin
        f8_n[c] <= 26'(f7_n[c] >>> f7_s);
      end
      f8_zero <= f7_zero;
      f9_d[0] <= 58'(f8_n[0]) * 58'(v0_q[7].x);
      f9_d[1] <= 58'(f8_n[1]) * 58'(v0_q[7].y);
      f9_d[2] <= 58'(f8_n[2]) * 58'(v0_q[7].z);
      for (int c = 0; c < 3; c++) begin
        f9_q[c] <= 52'(f8_n[c]) * 52'(f8_n[c]);
      end
      f9_apos  <= f8_n[2][25];
      f9_zero  <= f8_zero;
      f10_dot  <= 60'(f9_d[0]) + 60'(f9_d[1]) + 60'(f9_d[2]);
      f10_s    <= 54'(f9_q[0]) + 54'(f9_q[1]) + 54'(f9_q[2]);
      f10_a2   <= f9_q[2];
      f10_apos <= f9_apos;
      f10_zero <= f9_zero;
      for (int k = 0; k < 13; k++) begin
        f11_kk[k] <= 62'(f10_s) * 62'((k + 1) * (k + 1));
      end
      f11_r    <= 62'(f10_a2) * 62'(169);
      f11_apos <= f10_apos;
      f11_keep <= !f10_zero && f10_dot[59];
      res.keep  <= f11_keep;
      res.level <= (!f11_apos || cnt == 4'd13) ? 4'd0 : cnt;
    end
  end

endmodule

// ===== tb/tb_triangle_transform_cull_shade_project.sv =====
`timescale 1ns / 1ps
module tb_triangle_transform_cull_shade_project;
  import ttcsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  ttcsp_tri_if tri_ch();
  ttcsp_res_if res_ch();
  ttcsp_cfg_if cfg_ch();

  triangle_transform_cull_shade_project u_top (
    .clk(clk),
    .rst(rst),
    .triangle(tri_ch.sink),
    .result(res_ch.source),
    .cfg(cfg_ch.sink)
  );

  xform_t xf;
  tri_t tri_q[$];
  res_t screen_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic int fit_shift(longint v[], longint lim);
    int s;
    bit ok;
    for (s = 0; s < 62; s++) begin
      ok = 1;
      foreach (v[i]) begin
        if (fshr(v[i], s) < -lim || fshr(v[i], s) >= lim) ok = 0;
      end
      if (ok) return s;
    end
    return 62;
  endfunction

  function automatic void project_vertex(longint p[3], output longint sx, output longint sy,
                                         output longint zp);
    longint xn, yn, zn, xp, yp;
    xn = p[0] * longint'(xf.x_proj_scale);
    yn = p[1] * longint'(xf.y_proj_scale);
    zn = fshr(p[2] * PROJ_Q, 16) + PROJ_B;
    if (p[2] != 0) begin
      xp = xn / p[2];
      yp = yn / p[2];
      zp = (zn * 65536) / p[2];
    end else begin
      xp = fshr(xn, 16);
      yp = fshr(yn, 16);
      zp = zn;
    end
    xp = clip32(xp);
    yp = clip32(yp);
    sx = clip(((xp + 65536) * 512) / 131072, -32768, 32767);
    sy = clip(((yp + 65536) * 480) / 131072, -32768, 32767);
  endfunction

  function automatic bit predict_face(tri_t t, output res_t r);
    longint in_c[9];
    longint v[3][3];
    longint e[] = new[6];
    longint n[] = new[3];
    longint p[3];
    longint x, y, z, x1, y1, y2, z2, dot, a, s2, sx, sy, zp, depth;
    int sh, level;
    in_c = '{t.v0_x, t.v0_y, t.v0_z, t.v1_x, t.v1_y, t.v1_z, t.v2_x, t.v2_y, t.v2_z};
    for (int i = 0; i < 3; i++) begin
      x = in_c[i*3]; y = in_c[i*3+1]; z = in_c[i*3+2];
      x1 = clip32(fshr(x * xf.cos_z - y * xf.sin_z, 16));
      y1 = clip32(fshr(x * xf.sin_z + y * xf.cos_z, 16));
      y2 = clip32(fshr(y1 * xf.cos_x - z * xf.sin_x, 16));
      z2 = clip32(fshr(y1 * xf.sin_x + z * xf.cos_x, 16));
      v[i][0] = x1;
      v[i][1] = y2;
      v[i][2] = clip32(z2 + xf.depth_offset);
    end
    for (int i = 0; i < 3; i++) begin
      e[i] = v[1][i] - v[0][i];
      e[3+i] = v[2][i] - v[0][i];
    end
    sh = fit_shift(e, 64'sd1 << 29);
    foreach (e[i]) e[i] = fshr(e[i], sh);
    n[0] = e[1] * e[5] - e[2] * e[4];
    n[1] = e[2] * e[3] - e[0] * e[5];
    n[2] = e[0] * e[4] - e[1] * e[3];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return 0;
    sh = fit_shift(n, 64'sd1 << 25);
    foreach (n[i]) n[i] = fshr(n[i], sh);
    dot = n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2];
    if (dot >= 0) return 0;
    level = 0;
    a = -n[2];
    if (a > 0) begin
      s2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      for (int k = 1; k <= 13; k++) if (longint'(k * k) * s2 <= 169 * a * a) level = k;
      if (level == 13) level = 0;
    end
    depth = 0;
    for (int i = 0; i < 3; i++) begin
      p = v[i];
      project_vertex(p, sx, sy, zp);
      depth += zp;
      if (i == 0) begin r.screen_x0 = sx[15:0]; r.screen_y0 = sy[15:0]; end
      if (i == 1) begin r.screen_x1 = sx[15:0]; r.screen_y1 = sy[15:0]; end
      if (i == 2) begin r.screen_x2 = sx[15:0]; r.screen_y2 = sy[15:0]; end
    end
    r.depth_sum = clip32(depth);
    r.shade_level = level[3:0];
    return 1;
  endfunction

  task automatic queue_face(tri_t t);
    tri_q.insert(tri_q.size(), t);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tri_ch.valid <= 1'b0;
    end else begin
      if (tri_ch.valid && tri_ch.ready) begin
        void'(tri_q.pop_front());
      end
      if ((tri_ch.valid && !tri_ch.ready) ||
          (tri_q.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        tri_ch.valid <= 1'b1;
        tri_ch.data <= tri_q[0];
      end else begin
        tri_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t r;
    bit hit;
    if (tri_ch.valid && tri_ch.ready && !rst) begin
      hit = predict_face(tri_ch.data, r);
      if (hit) screen_q.insert(screen_q.size(), r);
    end
    if (res_ch.valid && res_ch.ready && !rst) begin
      if (screen_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, res_ch.data);
        errors++;
      end else begin
        r = screen_q.pop_front();
        if (r !== res_ch.data) begin
          $display("%0t mismatch expected %h actual %h", $time, r, res_ch.data);
          errors++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_COS_Z: xf.cos_z = val[17:0];
      REG_SIN_Z: xf.sin_z = val[17:0];
      REG_COS_X: xf.cos_x = val[17:0];
      REG_SIN_X: xf.sin_x = val[17:0];
      REG_DEPTH_OFFSET: xf.depth_offset = val;
      REG_X_PROJ_SCALE: xf.x_proj_scale = val[23:0];
      REG_Y_PROJ_SCALE: xf.y_proj_scale = val[23:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (tri_q.size() != 0 || tri_ch.valid || screen_q.size() != 0) @(posedge clk);
    repeat (LANE_LAT + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic tri_t rnd_face(int mode);
    tri_t t;
    t = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
         rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
         rnd_coord(mode)};
    if ($urandom_range(3) == 0) begin
      t.v2_x = t.v1_x; t.v2_y = t.v1_y; t.v2_z = t.v1_z;
    end
    return t;
  endfunction

  task automatic push_faces(int count);
    tri_t t;
    for (int i = 0; i < count; i++) begin
      t = rnd_face($urandom_range(2));
      queue_face(t);
      if ($urandom_range(1)) begin
        t.v1_x = t.v2_x; t.v1_y = t.v2_y; t.v1_z = t.v2_z;
        t.v2_x = tri_q[$].v1_x; t.v2_y = tri_q[$].v1_y; t.v2_z = tri_q[$].v1_z;
        queue_face(t);
        i++;
      end
    end
  endtask

  initial begin
    logic [31:0] w;
    xf = '{COS_Z_RST, SIN_Z_RST, COS_X_RST, SIN_X_RST, DEPTH_OFFSET_RST,
           X_PROJ_SCALE_RST, Y_PROJ_SCALE_RST};
    tri_ch.valid = 1'b0;
    tri_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_face('{32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                 32'h8000_0000, 0, 32'h7fff_ffff});
    queue_face('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_face('{-65536, -65536, 0, 65536, -65536, 0, 0, 65536, 0});
    queue_face('{-65536, -65536, 0, 0, 65536, 0, 65536, -65536, 0});
    queue_face('{-65536, 0, -524288, 65536, 0, -524288, 0, 65536, -524288});
    queue_face('{-65536, 0, -524288, 0, 65536, -524288, 65536, 0, -524288});
    queue_face('{0, 0, 65536, 65536, 0, 131072, 0, 65536, 65536});
    queue_face('{0, 0, 0, 65536, 0, 65536, 0, 65536, 0});
    queue_face('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    queue_face('{32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000,
                 0, 0, 32'h8000_0000});
    queue_face('{1, 0, -524288, 0, 1, -524288, 0, 0, -524288});
    queue_face('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                 32'h5555_5555});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (ph)
        0: ;
        1: begin
          write_reg(REG_COS_Z, 32'h0002_0000); write_reg(REG_SIN_Z, 32'h0001_0000);
          write_reg(REG_COS_X, 32'h0003_0000); write_reg(REG_SIN_X, 32'h0001_0000);
          write_reg(REG_DEPTH_OFFSET, 32'h8000_0000);
          write_reg(REG_X_PROJ_SCALE, 32'h00ff_ffff); write_reg(REG_Y_PROJ_SCALE, 0);
        end
        2: begin
          write_reg(REG_COS_Z, 32'h0001_ffff); write_reg(REG_SIN_Z, 32'h0002_0001);
          write_reg(REG_COS_X, 0); write_reg(REG_SIN_X, 32'h0003_ffff);
          write_reg(REG_DEPTH_OFFSET, 32'h7fff_ffff);
          write_reg(REG_X_PROJ_SCALE, 0); write_reg(REG_Y_PROJ_SCALE, 32'hffff_ffff);
        end
        3: begin
          write_reg(REG_DEPTH_OFFSET, 0);
          write_reg(reg_idx_t'(3'd7), $urandom());
        end
        default: begin
          w = $urandom_range(0, 131072) - 65536; write_reg(REG_COS_Z, w);
          w = $urandom_range(0, 131072) - 65536; write_reg(REG_SIN_Z, w);
          w = $urandom_range(0, 131072) - 65536; write_reg(REG_COS_X, w);
          w = $urandom_range(0, 131072) - 65536; write_reg(REG_SIN_X, w);
          write_reg(REG_DEPTH_OFFSET, $urandom_range(0, 32'h0080_0000) - 32'h0040_0000);
          write_reg(REG_X_PROJ_SCALE, $urandom());
          write_reg(REG_Y_PROJ_SCALE, $urandom_range(0, 32'h0002_0000));
        end
      endcase
      push_faces(110);
      while (tri_q.size() != 0) @(posedge clk);
      while (screen_q.size() != 0) @(posedge clk);
      push_faces(110);
      drain();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule
